FILE: sv/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg: shared types and constants for the TCP flow classifier
// Transaction structs, command and verdict codes, header length constants.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam logic [6:0] ETH_HDR_BYTES   = 7'd14;
  localparam logic [6:0] IP_MIN_HDR_LEN  = 7'd20;
  localparam logic [6:0] TCP_MIN_HDR_LEN = 7'd20;
  localparam logic [7:0] TCP_PROTO_NUM   = 8'd6;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  localparam logic [3:0] V_MATCHED     = 4'd0;
  localparam logic [3:0] V_TOO_SHORT   = 4'd1;
  localparam logic [3:0] V_NOT_TCP     = 4'd2;
  localparam logic [3:0] V_NO_FLOW     = 4'd3;
  localparam logic [3:0] V_ADDED       = 4'd4;
  localparam logic [3:0] V_DUPLICATE   = 4'd5;
  localparam logic [3:0] V_FULL        = 4'd6;
  localparam logic [3:0] V_REMOVED     = 4'd7;
  localparam logic [3:0] V_REMOVE_MISS = 4'd8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] frame_len;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [31:0] local_ip;
    logic [31:0] remote_ip;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [7:0]  ring_id;
  } req_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic [7:0] match_ring;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] local_ip;
    logic [31:0] remote_ip;
    logic [15:0] local_port;
    logic [15:0] remote_port;
  } flow_key_t;

  typedef struct packed {
    logic      valid;
    flow_key_t key;
    logic [7:0] ring;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic rd_en;
    logic commit;
    logic respond;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic early;
  } stat_t;

endpackage

FILE: sv/tfc_datapath.sv
// ----------------------------------------------------------------------------
// tfc_datapath: flow table memory, sweep counter and match tracking
// Holds the request, scans the table one entry per cycle, forms the verdict.
// ----------------------------------------------------------------------------
module tfc_datapath #(
  parameter int TABLE_ENTRIES = tfc_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  tfc_pkg::req_t  req,
  input  tfc_pkg::ctl_t  ctl,
  output tfc_pkg::stat_t stat,
  output tfc_pkg::rsp_t  rsp
);
  import tfc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t           mem [TABLE_ENTRIES];
  req_t             cur;
  flow_key_t        cur_key;
  logic [IDX_W-1:0] cnt;
  entry_t           rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       hit_ring;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             too_short;
  logic             not_tcp;
  logic [6:0]       tcp_min;
  logic             rd_match;
  logic             rd_free;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  rsp_t             rsp_next;

  assign cur_key = '{protocol: cur.protocol, local_ip: cur.local_ip,
                     remote_ip: cur.remote_ip, local_port: cur.local_port,
                     remote_port: cur.remote_port};

  // header length checks
  assign tcp_min   = ETH_HDR_BYTES + {1'b0, cur.header_words, 2'b00} + TCP_MIN_HDR_LEN;
  assign too_short = cur.frame_len < {9'd0, ETH_HDR_BYTES + IP_MIN_HDR_LEN};
  assign not_tcp   = (cur.protocol != TCP_PROTO_NUM) || (cur.frame_len < {9'd0, tcp_min});

  assign stat.cnt_last = (cnt == LAST_IDX);
  assign stat.early    = ((cur.cmd == CMD_CLASSIFY) && (too_short || not_tcp)) ||
                         ((cur.cmd != CMD_ADD) && (cur.cmd != CMD_REMOVE) &&
                          (cur.cmd != CMD_CLASSIFY));

  assign rd_match = rd_vld && rd_data.valid && (rd_data.key == cur_key);
  assign rd_free  = rd_vld && !rd_data.valid;

  // single write port: clearing pass, add commit or remove commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '{valid: 1'b0, key: cur_key, ring: cur.ring_id};
    if (ctl.clr_wr) begin
      wr_en = 1'b1;
    end else if (ctl.commit) begin
      if (cur.cmd == CMD_ADD && !hit && free_found) begin
        wr_en         = 1'b1;
        wr_addr       = free_idx;
        wr_data.valid = 1'b1;
      end else if (cur.cmd == CMD_REMOVE && hit) begin
        wr_en   = 1'b1;
        wr_addr = hit_idx;
      end
    end
  end

  always_comb begin
    rsp_next = '{verdict: V_NO_FLOW, match_ring: 8'd0};
    case (cur.cmd)
      CMD_ADD: begin
        rsp_next.verdict = hit ? V_DUPLICATE : (free_found ? V_ADDED : V_FULL);
      end
      CMD_REMOVE: begin
        rsp_next.verdict = hit ? V_REMOVED : V_REMOVE_MISS;
      end
      CMD_CLASSIFY: begin
        if (too_short) begin
          rsp_next.verdict = V_TOO_SHORT;
        end else if (not_tcp) begin
          rsp_next.verdict = V_NOT_TCP;
        end else if (hit) begin
          rsp_next.verdict    = V_MATCHED;
          rsp_next.match_ring = hit_ring;
        end
      end
      default: begin
        rsp_next.verdict = V_NO_FLOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
      if (ctl.cnt_clr) begin
        cnt <= '0;
      end else if (ctl.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (ctl.load) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (rd_match && !hit) begin
          hit <= 1'b1;
        end
        if (rd_free && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= req;
    end
    if (ctl.rd_en) begin
      rd_idx <= cnt;
    end
    if (rd_match && !hit) begin
      hit_idx  <= rd_idx;
      hit_ring <= rd_data.ring;
    end
    if (rd_free && !free_found) begin
      free_idx <= rd_idx;
    end
    if (ctl.respond) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: sv/tfc_ctrl.sv
// ----------------------------------------------------------------------------
// tfc_ctrl: sequencer for the TCP flow classifier
// Clearing pass after reset, then accept, check (early response for rejected requests), table sweep and commit.
// ----------------------------------------------------------------------------
module tfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tfc_pkg::stat_t stat,
  output tfc_pkg::ctl_t  ctl,
  output logic           busy,
  output logic           done
);
  import tfc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          ctl.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl.load    = 1'b1;
          ctl.cnt_clr = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.early) begin
          ctl.respond = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd_en   = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          ctl.cnt_clr = 1'b1;
          state_next  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        ctl.commit  = 1'b1;
        ctl.respond = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.respond;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> $past(state == ST_WAIT))
    else $error("commit without completed sweep");
`endif

endmodule

FILE: sv/tcp_flow_classifier.sv
// ----------------------------------------------------------------------------
// tcp_flow_classifier: exact-match TCP five-tuple table with ring lookup
// Add, remove and classify transactions against a table of flow keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req and raise start; the transaction is taken at a
//   rising edge with start high and busy low. Output channel: rsp carries
//   the verdict and ring when done, high for exactly one cycle, rises; the
//   receiver must take it then, there is no back pressure.
// Sequencing:
//   Classify transactions rejected on length or protocol, and unused
//   commands, raise done from the check state. Every other transaction
//   sweeps the table one entry per cycle through the single read port of
//   the table memory, then passes a wait state and a finish state, from
//   which it commits and raises done. busy drops in the cycle done is
//   high, so a new transaction may be accepted then, not while busy.
// Reset:
//   rst (synchronous) starts a clearing pass that marks all TABLE_ENTRIES
//   entries invalid, one per cycle; busy stays high until the pass ends.
//   Add uses the lowest free entry; a duplicate key keeps its stored ring.
// ----------------------------------------------------------------------------
module tcp_flow_classifier #(
  parameter int TABLE_ENTRIES = tfc_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tfc_pkg::req_t req,
  output logic          done,
  output tfc_pkg::rsp_t rsp
);
  import tfc_pkg::*;

  // command / status between sequencer and datapath
  ctl_t  ctl;
  stat_t stat;

  tfc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // table memory, sweep counter, match tracking and result register
  tfc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
